### src/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

    localparam int CAPACITY = 64;
    // wide enough to hold the entry count itself
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // neighbour of the head cell, head itself for a single-entry table
    localparam int NEXT_IDX = (CAPACITY > 1) ? 1 : 0;

    typedef logic [1:0] t_func;
    typedef logic [1:0] t_status;

    localparam t_func OP_LOOKUP = 2'd0;
    localparam t_func OP_WRITE  = 2'd1;
    localparam t_func OP_DELETE = 2'd2;
    localparam t_func OP_CLEAR  = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_NOKEY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef struct packed {
        logic [63:0] value;
        logic [31:0] key;
    } t_entry;

    typedef struct packed {
        logic   shift;
        t_entry fb;
    } t_ring_ctl;

    typedef struct packed {
        t_status     status;
        logic [6:0]  entry_count;
        logic [63:0] value_out;
        logic        found;
    } t_result;

endpackage

`default_nettype wire

### src/lkv_cell.sv
`default_nettype none

module lkv_cell
    import lkv_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_shift,
    input  wire t_entry i_entry,
    output t_entry      o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

### src/lkv_ctrl.sv
`default_nettype none

module lkv_ctrl
    import lkv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_func       i_func,
    input  wire logic [31:0] i_key,
    input  wire logic [63:0] i_value,
    input  wire t_entry      i_head,
    input  wire t_entry      i_next,
    output t_ring_ctl        o_ring,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_result          o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CAPACITY - 1);

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_step;
    logic [CNT_W-1:0] r_count;
    logic             r_found;
    logic             r_ins;
    logic             r_ovalid;
    t_func            r_op;
    logic [31:0]      r_key;
    logic [63:0]      r_value;
    logic [63:0]      r_vout;
    t_result          r_res;

    logic             w_hit;
    logic             n_found;
    logic             n_ins;
    logic [63:0]      n_vout;
    t_entry           w_fb;
    logic             w_load;
    logic [CNT_W-1:0] n_count;
    t_status          w_status;

    always_comb begin
        n_found = r_found;
        n_ins   = r_ins;
        n_vout  = r_vout;
        w_fb    = i_head;
        w_hit   = (r_state == S_RUN) && (r_step < r_count) && !r_found
                  && (i_head.key == r_key);
        if (r_state == S_RUN) begin
            if (w_hit) begin
                n_found = 1'b1;
            end
            case (r_op)
                OP_LOOKUP: begin
                    if (w_hit) begin
                        n_vout = i_head.value;
                    end
                end
                OP_WRITE: begin
                    if (w_hit) begin
                        w_fb.value = r_value;
                    end else if (!r_found && (r_step == r_count)) begin
                        // first free slot passes the head: append
                        w_fb.key   = r_key;
                        w_fb.value = r_value;
                        n_ins      = 1'b1;
                    end
                end
                OP_DELETE: begin
                    // from the match on, pull entries one place down
                    if (w_hit || r_found) begin
                        w_fb = i_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_count  = r_count;
        w_status = ST_OK;
        case (r_op)
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_WRITE: begin
                if (r_ins) begin
                    n_count = r_count + CNT_W'(1);
                end else if (!r_found) begin
                    w_status = ST_FULL;
                end
            end
            OP_DELETE: begin
                if (r_found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    w_status = ST_NOKEY;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_load = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_count  <= '0;
            r_found  <= 1'b0;
            r_ins    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_found <= 1'b0;
                        r_ins   <= 1'b0;
                        r_step  <= '0;
                        r_state <= (i_func == OP_CLEAR) ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    r_found <= n_found;
                    r_ins   <= n_ins;
                    r_step  <= r_step + CNT_W'(1);
                    if (r_step == LAST_STEP) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_count  <= n_count;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_op    <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
            r_vout  <= '0;
        end else if (r_state == S_RUN) begin
            r_vout  <= n_vout;
        end
        if (w_load) begin
            r_res.found       <= r_found;
            r_res.value_out   <= r_vout;
            r_res.entry_count <= 7'(n_count);
            r_res.status      <= w_status;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_ring.shift = (r_state == S_RUN);
    assign o_ring.fb    = w_fb;
    assign o_out_valid  = r_ovalid;
    assign o_res        = r_res;

endmodule

`default_nettype wire

### src/linear_key_value_table.sv
`default_nettype none

// channel   direction  tdata (low bit up)                               tuser
// s_axis    in         key[31:0], value[95:32]                           func[1:0]
// m_axis    out        found[0], value_out[64:1], entry_count[71:65],   -
//                      status[73:72], zero pad[79:74]
//
// a clear goes straight to the load of the output register; lookup, write and delete
// first take one full turn of the cell ring past the head cell, then that load; the
// next word can be taken once the result is loaded
// reset clears the entry count, the sequencer and the result valid; cells are not reset
// a result waits in the output register while the next word is accepted
// a finished word stalls in the sequencer only while the output register is still full

module linear_key_value_table
    import lkv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [95:0] i_s_axis_tdata,   // key, value
    input  wire logic [1:0]  i_s_axis_tuser,   // func
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata    // found, value_out, entry_count, status
);

    // ring of cells: cell 0 is the head, every cell takes from its upper
    // neighbour, the top cell takes the feedback word from the sequencer
    t_entry    w_cell [CAPACITY];
    t_ring_ctl w_ring;
    t_result   w_res;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_entry w_in;
        if (gi == CAPACITY - 1) begin : g_top
            assign w_in = w_ring.fb;
        end else begin : g_mid
            assign w_in = w_cell[gi+1];
        end
        lkv_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_ring.shift),
            .i_entry (w_in),
            .o_entry (w_cell[gi])
        );
    end

    // sequencer: scans the head once per step, edits the feedback word
    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_func      (i_s_axis_tuser),
        .i_key       (i_s_axis_tdata[31:0]),
        .i_value     (i_s_axis_tdata[95:32]),
        .i_head      (w_cell[0]),
        .i_next      (w_cell[NEXT_IDX]),
        .o_ring      (w_ring),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_res       (w_res)
    );

    // pad result word to whole bytes
    assign o_m_axis_tdata = {6'b0, w_res};

endmodule

`default_nettype wire

### src/lkv_checker.sv
`default_nettype none

module lkv_checker
    import lkv_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [95:0] i_s_axis_tdata,
    input wire logic [1:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [79:0] o_m_axis_tdata
);

    a_valid_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[71:65] <= 7'(CAPACITY)))
        else $error("entry count beyond capacity");

    a_err_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[73:72] != ST_OK)
        |-> !o_m_axis_tdata[0] && (o_m_axis_tdata[64:1] == 64'd0))
        else $error("error status with found or value set");

    a_clear_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == OP_CLEAR)
        && !o_m_axis_tvalid
        |=> ##1 o_m_axis_tvalid && (o_m_axis_tdata[79:0] == 80'd0))
        else $error("clear result not an empty ok word");

endmodule

bind linear_key_value_table lkv_checker u_lkv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
